// ===== sv/psect_pkg.sv =====
package psect_pkg;

    // Fixed field widths
    localparam int RADIUS_W   = 11;
    localparam int START_W    = 10;
    localparam int SWEEP_W    = 9;
    localparam int ANGLE_W    = 9;
    localparam int OUTER_W    = RADIUS_W + 1;
    localparam int OUTER_SQ_W = 2 * OUTER_W;
    localparam int CFG_IDX_W  = 3;

    // Quotient bits of 45*min/max, which never exceeds 45
    localparam int Q_W = 6;

    // Angle constants in degrees
    localparam int DEG_45  = 45;
    localparam int DEG_90  = 90;
    localparam int DEG_180 = 180;
    localparam int DEG_360 = 360;

    // Register reset values
    localparam logic [START_W-1:0] START_RST = 10'd270;
    localparam logic [SWEEP_W-1:0] SWEEP_RST = 9'd360;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_RADIUS      = 3'd2,
        CFG_START_ANGLE = 3'd3,
        CFG_SWEEP       = 3'd4
    } t_cfg_idx;

    // Per-word flags that travel with the divider data
    typedef struct packed {
        logic valid;
        logic in_circle;
        logic neg_x;
        logic neg_y;
        logic oct_low;
    } t_side;

endpackage

// ===== sv/psect_front.sv =====
module psect_front #(
    parameter int COORD_BITS = 13
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [COORD_BITS-1:0]        i_pixel_x,
    input  logic signed [COORD_BITS-1:0]        i_pixel_y,
    input  logic signed [COORD_BITS-1:0]        i_center_x,
    input  logic signed [COORD_BITS-1:0]        i_center_y,
    input  logic [psect_pkg::RADIUS_W-1:0]      i_radius,
    output psect_pkg::t_side                    o_side,
    output logic [COORD_BITS+psect_pkg::Q_W:0]  o_num,
    output logic [COORD_BITS:0]                 o_den
);
    import psect_pkg::*;

    localparam int D_W   = COORD_BITS + 1;
    localparam int NUM_W = D_W + Q_W;
    localparam int SQ_W  = 2 * D_W;
    localparam int CMP_W = (SQ_W + 1 > OUTER_SQ_W) ? SQ_W + 1 : OUTER_SQ_W;

    // Stage 1: offsets from the center
    logic                  r1_valid;
    logic signed [D_W-1:0] r1_dx, r1_dy;
    logic signed [D_W-1:0] n1_dx, n1_dy;

    assign n1_dx = D_W'(i_pixel_x) - D_W'(i_center_x);
    assign n1_dy = D_W'(i_pixel_y) - D_W'(i_center_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx <= n1_dx;
            r1_dy <= n1_dy;
        end
    end

    // Stage 2: magnitudes, octant, dividend and squares
    logic [D_W-1:0]        ax, ay, mn, mx;
    logic [NUM_W-1:0]      n2_num;
    logic [D_W-1:0]        n2_den;
    logic signed [SQ_W-1:0] n2_sq_x, n2_sq_y;
    logic [OUTER_W-1:0]    outer;
    logic [OUTER_SQ_W-1:0] n2_outer_sq;
    t_side                 n2_side;

    always_comb begin
        ax = r1_dx[D_W-1] ? D_W'(-r1_dx) : D_W'(r1_dx);
        ay = r1_dy[D_W-1] ? D_W'(-r1_dy) : D_W'(r1_dy);
        n2_side.valid     = r1_valid;
        n2_side.in_circle = 1'b0;
        n2_side.neg_x     = r1_dx[D_W-1];
        n2_side.neg_y     = r1_dy[D_W-1];
        n2_side.oct_low   = (ax >= ay);
        mn = n2_side.oct_low ? ay : ax;
        mx = n2_side.oct_low ? ax : ay;
        n2_num = NUM_W'(mn) * NUM_W'(DEG_45);
        // pixel on the center: divide 0 by 1 so the quotient comes out 0
        n2_den = (mx == '0) ? D_W'(1) : mx;
        n2_sq_x = r1_dx * r1_dx;
        n2_sq_y = r1_dy * r1_dy;
        outer = OUTER_W'(i_radius) + OUTER_W'(1);
        n2_outer_sq = OUTER_SQ_W'(outer) * OUTER_SQ_W'(outer);
    end

    t_side                 r2_side;
    logic [NUM_W-1:0]      r2_num;
    logic [D_W-1:0]        r2_den;
    logic [SQ_W-1:0]       r2_sq_x, r2_sq_y;
    logic [OUTER_SQ_W-1:0] r2_outer_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side.valid <= 1'b0;
        end else if (i_en) begin
            r2_side <= n2_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_num      <= n2_num;
            r2_den      <= n2_den;
            r2_sq_x     <= $unsigned(n2_sq_x);
            r2_sq_y     <= $unsigned(n2_sq_y);
            r2_outer_sq <= n2_outer_sq;
        end
    end

    // Stage 3: radius test
    logic [CMP_W-1:0] dist_sq;
    t_side            n3_side;

    always_comb begin
        dist_sq = CMP_W'(r2_sq_x) + CMP_W'(r2_sq_y);
        n3_side = r2_side;
        n3_side.in_circle = (dist_sq <= CMP_W'(r2_outer_sq));
    end

    t_side            r3_side;
    logic [NUM_W-1:0] r3_num;
    logic [D_W-1:0]   r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side.valid <= 1'b0;
        end else if (i_en) begin
            r3_side <= n3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_num <= r2_num;
            r3_den <= r2_den;
        end
    end

    assign o_side = r3_side;
    assign o_num  = r3_num;
    assign o_den  = r3_den;

endmodule

// ===== sv/psect_div_cell.sv =====
module psect_div_cell #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 14,
    parameter int SHIFT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  psect_pkg::t_side            i_side,
    input  logic [NUM_W-1:0]            i_rem,
    input  logic [DEN_W-1:0]            i_den,
    input  logic [psect_pkg::Q_W-1:0]   i_quo,
    output psect_pkg::t_side            o_side,
    output logic [NUM_W-1:0]            o_rem,
    output logic [DEN_W-1:0]            o_den,
    output logic [psect_pkg::Q_W-1:0]   o_quo
);
    import psect_pkg::*;

    // Trial subtract of the divisor at this cell's weight
    logic [NUM_W-1:0] den_sh;
    logic             take;
    logic [NUM_W-1:0] n_rem;
    logic [Q_W-1:0]   n_quo;

    always_comb begin
        den_sh = NUM_W'(i_den) << SHIFT;
        take   = (i_rem >= den_sh);
        n_rem  = take ? (i_rem - den_sh) : i_rem;
        n_quo  = i_quo;
        n_quo[SHIFT] = take;
    end

    t_side            r_side;
    logic [NUM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    // Hand the partial result to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quo  = r_quo;

endmodule

// ===== sv/psect_back.sv =====
module psect_back #(
    parameter int ANGLE_PAD_DEG = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  psect_pkg::t_side                  i_side,
    input  logic [psect_pkg::Q_W-1:0]         i_quo,
    input  logic [psect_pkg::START_W-1:0]     i_start,
    input  logic [psect_pkg::SWEEP_W-1:0]     i_sweep,
    input  logic                              i_stall,
    output logic                              o_en,
    output logic                              o_valid,
    output logic                              o_inside_res,
    output logic [psect_pkg::ANGLE_W-1:0]     o_pixel_angle
);
    import psect_pkg::*;

    localparam int PAD2 = 2 * ANGLE_PAD_DEG;
    localparam int T_W  = START_W + 1;
    localparam int DD_W = ANGLE_W + 1;
    localparam int PS_W = SWEEP_W + 1;

    logic en;

    // Unfold the octant quotient into a full-circle angle
    logic [ANGLE_W-1:0] a0, a1, n_angle;

    always_comb begin
        a0 = i_side.oct_low ? ANGLE_W'(i_quo) : (ANGLE_W'(DEG_90) - ANGLE_W'(i_quo));
        a1 = i_side.neg_x ? (ANGLE_W'(DEG_180) - a0) : a0;
        // a zero angle just below the axis wraps back to zero, not a full turn
        n_angle = (i_side.neg_y && (a1 != '0)) ? (ANGLE_W'(DEG_360) - a1) : a1;
    end

    logic               r_b_valid;
    logic               r_b_circle;
    logic [ANGLE_W-1:0] r_b_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_circle <= i_side.in_circle;
            r_b_angle  <= n_angle;
        end
    end

    // Window test against the padded start and sweep
    logic [T_W-1:0]     t_start, t_red;
    logic [ANGLE_W-1:0] pstart;
    logic [DD_W-1:0]    rel;
    logic [PS_W-1:0]    psweep;
    logic               full;
    logic               n_inside;

    always_comb begin
        t_start = T_W'(i_start) + T_W'(DEG_360) - T_W'(ANGLE_PAD_DEG);
        if (t_start >= T_W'(3 * DEG_360)) begin
            t_red = t_start - T_W'(3 * DEG_360);
        end else if (t_start >= T_W'(2 * DEG_360)) begin
            t_red = t_start - T_W'(2 * DEG_360);
        end else if (t_start >= T_W'(DEG_360)) begin
            t_red = t_start - T_W'(DEG_360);
        end else begin
            t_red = t_start;
        end
        pstart = t_red[ANGLE_W-1:0];
        rel = {1'b0, r_b_angle} - {1'b0, pstart};
        if (rel[DD_W-1]) begin
            rel = rel + DD_W'(DEG_360);
        end
        psweep = PS_W'(i_sweep) + PS_W'(PAD2);
        full = (i_sweep >= SWEEP_W'(DEG_360)) || (psweep >= PS_W'(DEG_360));
        n_inside = r_b_circle && (full || (rel <= DD_W'(psweep)));
    end

    // Output register with a skid word behind it
    logic               r_out_valid, r_skid_valid;
    logic               r_out_inside, r_skid_inside;
    logic [ANGLE_W-1:0] r_out_angle, r_skid_angle;
    logic               out_load;

    assign en       = !r_skid_valid;
    assign out_load = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_skid_valid <= 1'b0;
            end
        end else if (out_load) begin
            r_out_valid <= r_b_valid;
        end else if (r_b_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!i_stall) begin
                r_out_inside <= r_skid_inside;
                r_out_angle  <= r_skid_angle;
            end
        end else if (out_load) begin
            r_out_inside <= n_inside;
            r_out_angle  <= r_b_angle;
        end else begin
            r_skid_inside <= n_inside;
            r_skid_angle  <= r_b_angle;
        end
    end

    assign o_en          = en;
    assign o_valid       = r_out_valid;
    assign o_inside_res  = r_out_inside;
    assign o_pixel_angle = r_out_angle;

endmodule

// ===== sv/pie_sector_point_test.sv =====
// Pie sector hit test. Each word on the input carries one pixel; the block
// returns one word with the inside flag and the approximate angle of that
// pixel around the center (0..359 degrees, screen y pointing down). The
// block takes a new pixel every clock while o_stall is low; each pixel passes
// through three front stages (offsets; magnitudes, squares and dividend;
// radius test), six divider cells that each settle one bit of 45*min/max,
// one stage that unfolds the angle, and the output register.
// A one-word skid behind the output register keeps a pixel arriving while a
// result is stalled; o_stall rises only when that skid word is occupied.
// Registers are written through the plain write port between bursts, a rule
// the block does not enforce, and take effect at once for the next pixel.
module pie_sector_point_test #(
    parameter int COORD_BITS    = 13,
    parameter int ANGLE_PAD_DEG = 2,
    localparam int CFG_W = (COORD_BITS > psect_pkg::RADIUS_W) ? COORD_BITS
                                                               : psect_pkg::RADIUS_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [COORD_BITS-1:0]       i_pixel_x,
    input  logic signed [COORD_BITS-1:0]       i_pixel_y,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_inside_res,
    output logic [psect_pkg::ANGLE_W-1:0]      o_pixel_angle,
    input  logic                               i_cfg_wr_en,
    input  logic [psect_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]                   i_cfg_data
);
    import psect_pkg::*;

    localparam int D_W   = COORD_BITS + 1;
    localparam int NUM_W = D_W + Q_W;

    // Configuration registers
    logic signed [COORD_BITS-1:0] r_center_x, r_center_y;
    logic [RADIUS_W-1:0]          r_radius;
    logic [START_W-1:0]           r_start;
    logic [SWEEP_W-1:0]           r_sweep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
            r_start    <= START_RST;
            r_sweep    <= SWEEP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CENTER_X:    r_center_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:    r_center_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_RADIUS:      r_radius   <= i_cfg_data[RADIUS_W-1:0];
                CFG_START_ANGLE: r_start    <= i_cfg_data[START_W-1:0];
                CFG_SWEEP:       r_sweep    <= i_cfg_data[SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;

    // Chain links between the front end, the cells and the back end
    t_side            side_c [Q_W+1];
    logic [NUM_W-1:0] rem_c  [Q_W+1];
    logic [D_W-1:0]   den_c  [Q_W+1];
    logic [Q_W-1:0]   quo_c  [Q_W+1];

    psect_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_radius   (r_radius),
        .o_side     (side_c[0]),
        .o_num      (rem_c[0]),
        .o_den      (den_c[0])
    );

    assign quo_c[0] = '0;

    // One divider cell per quotient bit, most significant first
    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        psect_div_cell #(
            .NUM_W (NUM_W),
            .DEN_W (D_W),
            .SHIFT (Q_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_side  (side_c[k]),
            .i_rem   (rem_c[k]),
            .i_den   (den_c[k]),
            .i_quo   (quo_c[k]),
            .o_side  (side_c[k+1]),
            .o_rem   (rem_c[k+1]),
            .o_den   (den_c[k+1]),
            .o_quo   (quo_c[k+1])
        );
    end

    psect_back #(
        .ANGLE_PAD_DEG (ANGLE_PAD_DEG)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_side        (side_c[Q_W]),
        .i_quo         (quo_c[Q_W]),
        .i_start       (r_start),
        .i_sweep       (r_sweep),
        .i_stall       (i_stall),
        .o_en          (en),
        .o_valid       (o_valid),
        .o_inside_res  (o_inside_res),
        .o_pixel_angle (o_pixel_angle)
    );

    assign o_stall = !en;

    // A parked skid word always sits behind a valid output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid word held with no output word");

    // The skid word only fills while the output word is stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("skid filled without a stalled output");

    // Draining the skid refills the output register
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !i_stall) |=> o_valid)
        else $error("skid word lost on drain");

    // Unfolded angle stays within one turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_angle < ANGLE_W'(DEG_360)))
        else $error("pixel angle out of range");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import psect_pkg::*;

    localparam int COORD_W     = 13;
    localparam int PAD_DEG     = 2;
    localparam int DATA_W      = 13;
    localparam int COORD_MIN   = -(1 << (COORD_W - 1));
    localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
    localparam int RADIUS_MAX  = (1 << RADIUS_W) - 1;
    localparam int START_MAX   = 719;
    localparam int DEG_270     = DEG_90 + DEG_180;
    localparam int SPARE_LO    = int'(CFG_SWEEP) + 1;
    localparam int SPARE_HI    = (1 << CFG_IDX_W) - 1;
    localparam int PHASE_CNT   = 12;
    localparam int PHASE_ITEMS = 94;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pixel_t;

    typedef struct packed {
        logic               hit;
        logic [ANGLE_W-1:0] angle;
    } hit_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      pix_valid = 1'b0;
    logic                      pix_stall;
    logic signed [COORD_W-1:0] pix_x     = '0;
    logic signed [COORD_W-1:0] pix_y     = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    logic                      res_inside;
    logic [ANGLE_W-1:0]        res_angle;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [DATA_W-1:0]         cfg_data  = '0;

    // Sector registers as the block should hold them
    logic signed [COORD_W-1:0] sec_cx;
    logic signed [COORD_W-1:0] sec_cy;
    logic [RADIUS_W-1:0]       sec_radius;
    logic [START_W-1:0]        sec_start;
    logic [SWEEP_W-1:0]        sec_sweep;

    pixel_t pixel_q[$];
    hit_t   hit_q[$];
    int     err_cnt    = 0;
    int     cycle_cnt  = 0;
    int     send_gap   = 0;
    int     stall_left = 0;
    bit     gaps_on    = 1'b0;
    bit     stalls_on  = 1'b0;

    pie_sector_point_test #(
        .COORD_BITS    (COORD_W),
        .ANGLE_PAD_DEG (PAD_DEG)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (pix_valid),
        .o_stall       (pix_stall),
        .i_pixel_x     (pix_x),
        .i_pixel_y     (pix_y),
        .o_valid       (res_valid),
        .i_stall       (res_stall),
        .o_inside_res  (res_inside),
        .o_pixel_angle (res_angle),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int wrap_deg(int v);
        int r;
        r = v % DEG_360;
        return (r < 0) ? r + DEG_360 : r;
    endfunction

    // Mostly no pause, some short ones, a few long ones
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Octant angle of the pixel and the padded sector hit test
    function automatic hit_t sector_hit(pixel_t p);
        int     dx, dy, ax, ay, a, psweep, pstart;
        longint dist_sq, outer;
        hit_t   h;
        dx = int'(p.x) - int'(sec_cx);
        dy = int'(p.y) - int'(sec_cy);
        if (dx == 0 && dy == 0) begin
            a = 0;
        end else if (dx == 0) begin
            a = (dy > 0) ? DEG_90 : DEG_270;
        end else if (dy == 0) begin
            a = (dx > 0) ? 0 : DEG_180;
        end else begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ax >= ay)
                a = (DEG_45 * ay) / ax;
            else
                a = DEG_90 - (DEG_45 * ax) / ay;
            if (dx < 0)
                a = DEG_180 - a;
            if (dy < 0)
                a = DEG_360 - a;
            a = wrap_deg(a);
        end
        outer   = longint'(sec_radius) + 1;
        dist_sq = longint'(dx) * dx + longint'(dy) * dy;
        h.angle = ANGLE_W'(a);
        h.hit   = 1'b0;
        if (dist_sq <= outer * outer) begin
            psweep = int'(sec_sweep) + 2 * PAD_DEG;
            if (int'(sec_sweep) >= DEG_360 || psweep >= DEG_360) begin
                h.hit = 1'b1;
            end else begin
                pstart = wrap_deg(int'(sec_start) - PAD_DEG);
                h.hit  = (wrap_deg(a - pstart) <= psweep);
            end
        end
        return h;
    endfunction

    // Drive one register write and track it; spare indexes change nothing
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DATA_W'(value);
        case (idx)
            CFG_CENTER_X:    sec_cx     = COORD_W'(value);
            CFG_CENTER_Y:    sec_cy     = COORD_W'(value);
            CFG_RADIUS:      sec_radius = RADIUS_W'(value);
            CFG_START_ANGLE: sec_start  = START_W'(value);
            CFG_SWEEP:       sec_sweep  = SWEEP_W'(value);
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every queued pixel is taken and every result is back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pixel_q.size() != 0 || pix_valid || hit_q.size() != 0);
    endtask

    task automatic push_pixel(input int x, input int y);
        pixel_t p;
        p.x = COORD_W'(x);
        p.y = COORD_W'(y);
        pixel_q.push_back(p);
    endtask

    // Pick a sector, leaning on the edges of each register's range
    task automatic random_setup();
        int cx, cy, rad, st, sw;
        case ($urandom_range(0, 3))
            0:       cx = COORD_MIN;
            1:       cx = COORD_MAX;
            default: cx = int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
        endcase
        case ($urandom_range(0, 3))
            0:       cy = COORD_MIN;
            1:       cy = COORD_MAX;
            default: cy = int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
        endcase
        case ($urandom_range(0, 4))
            0:       rad = 0;
            1:       rad = RADIUS_MAX;
            2, 3:    rad = $urandom_range(1, 40);
            default: rad = $urandom_range(0, RADIUS_MAX);
        endcase
        case ($urandom_range(0, 6))
            0:       st = 0;
            1:       st = START_MAX;
            2:       st = DEG_360;
            3:       st = $urandom_range(1, PAD_DEG);
            default: st = $urandom_range(0, START_MAX);
        endcase
        case ($urandom_range(0, 6))
            0:       sw = 0;
            1:       sw = DEG_360;
            2:       sw = DEG_360 - 2 * PAD_DEG - 1;
            3:       sw = DEG_360 - 2 * PAD_DEG;
            default: sw = $urandom_range(0, DEG_360);
        endcase
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_START_ANGLE, st);
        write_reg(CFG_SWEEP, sw);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(SPARE_LO, SPARE_HI)), $urandom);
        end_writes();
    endtask

    // Mostly pixels around the center, some axis hits, the rest anywhere
    task automatic push_random(input int n);
        int reach, offx, offy;
        repeat (n) begin
            reach = int'(sec_radius) + 3;
            if ($urandom_range(0, 9) < 3) begin
                push_pixel($urandom, $urandom);
            end else begin
                offx = int'($urandom_range(0, 2 * reach)) - reach;
                offy = int'($urandom_range(0, 2 * reach)) - reach;
                case ($urandom_range(0, 9))
                    0:       offx = 0;
                    1:       offy = 0;
                    default: ;
                endcase
                push_pixel(int'(sec_cx) + offx, int'(sec_cy) + offy);
            end
        end
    endtask

    // Feed pixel words from the pending queue, with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else if (!pix_valid || !pix_stall) begin
            if (send_gap > 0) begin
                pix_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end else if (pixel_q.size() != 0) begin
                pix_valid      <= 1'b1;
                {pix_x, pix_y} <= pixel_q.pop_front();
                send_gap       <= gaps_on ? pick_pause() : 0;
            end else begin
                pix_valid <= 1'b0;
            end
        end
    end

    // Stall the result side in random bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            res_stall  <= 1'b1;
            stall_left <= pick_pause();
        end else begin
            res_stall <= 1'b0;
        end
    end

    // Predict on each taken pixel, check each taken result against the oldest
    always @(posedge clk) begin
        hit_t want;
        if (rst_n && pix_valid && !pix_stall)
            hit_q.push_back(sector_hit({pix_x, pix_y}));
        if (rst_n && res_valid && !res_stall) begin
            if (hit_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result word: inside %0d, angle %0d",
                         $time, res_inside, res_angle);
            end else begin
                want = hit_q.pop_front();
                if (res_inside !== want.hit) begin
                    err_cnt++;
                    $display("%0t: inside flag mismatch: expected %0d, actual %0d",
                             $time, want.hit, res_inside);
                end
                if (res_angle !== want.angle) begin
                    err_cnt++;
                    $display("%0t: pixel angle mismatch: expected %0d, actual %0d",
                             $time, want.angle, res_angle);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int phase;
        sec_cx     = '0;
        sec_cy     = '0;
        sec_radius = '0;
        sec_start  = START_RST;
        sec_sweep  = SWEEP_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sector: tiny circle, full sweep; center, axes, corners
        push_pixel(0, 0);
        push_pixel(1, 0);
        push_pixel(0, 1);
        push_pixel(-1, 0);
        push_pixel(0, -1);
        push_pixel(1, 1);
        push_pixel(COORD_MAX, COORD_MAX);
        push_pixel(COORD_MIN, COORD_MIN);
        push_pixel(COORD_MIN, COORD_MAX);
        push_pixel(COORD_MAX, COORD_MIN);
        wait_drained();

        // Extreme registers: corner center, widest radius, zero sweep past 360
        write_reg(CFG_CENTER_X, COORD_MIN);
        write_reg(CFG_CENTER_Y, COORD_MAX);
        write_reg(CFG_RADIUS, RADIUS_MAX);
        write_reg(CFG_START_ANGLE, START_MAX);
        write_reg(CFG_SWEEP, 0);
        write_reg(CFG_IDX_W'(SPARE_LO), 0);
        write_reg(CFG_IDX_W'(SPARE_HI), 0);
        end_writes();
        push_pixel(COORD_MIN, COORD_MAX);
        push_pixel(COORD_MIN + 1, COORD_MAX);
        push_pixel(COORD_MIN, COORD_MAX - 1);
        push_pixel(COORD_MIN + 100, COORD_MAX - 5);
        push_pixel(COORD_MIN + 1096, COORD_MAX - 15);
        push_pixel(COORD_MIN + 596, COORD_MAX - 95);
        push_pixel(COORD_MIN + RADIUS_MAX, COORD_MAX);
        push_pixel(COORD_MIN + RADIUS_MAX + 1, COORD_MAX);
        push_pixel(COORD_MIN + RADIUS_MAX + 2, COORD_MAX);
        push_pixel(COORD_MAX, COORD_MIN);
        push_pixel(COORD_MIN + 3, COORD_MAX - 3);

        // Random sectors; first phase runs without idling
        for (phase = 0; phase < PHASE_CNT; phase++) begin
            wait_drained();
            gaps_on   = (phase != 0) && ($urandom_range(0, 3) != 0);
            stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            random_setup();
            push_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
